/* hw/rtl/pscc_pkg.sv */
`timescale 1ns / 1ps

package pscc_pkg;

    localparam int FRAME_W   = 48;
    localparam int ADC_W     = 20;
    localparam int PRESS_W   = 32;
    localparam int COEF_W    = 16;
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 5;
    localparam int DSR_W     = 32;
    localparam int DIV_STEPS = 64;

    // Register indexes, taken from paddr[4:3]
    localparam logic [1:0] REG_TEMP       = 2'd0;
    localparam logic [1:0] REG_PRESS_LOW  = 2'd1;
    localparam logic [1:0] REG_PRESS_HIGH = 2'd2;
    localparam logic [1:0] REG_PRESS_NINE = 2'd3;

    localparam logic signed [23:0] T_OFFSET     = 24'sd128000;
    localparam logic        [20:0] P_FULL_SCALE = 21'd1048576;
    localparam logic        [11:0] P_SCALE      = 12'd3125;

    typedef struct packed {
        logic [COEF_W-1:0] t1;
        logic [COEF_W-1:0] t2;
        logic [COEF_W-1:0] t3;
        logic [COEF_W-1:0] p1;
        logic [COEF_W-1:0] p2;
        logic [COEF_W-1:0] p3;
        logic [COEF_W-1:0] p4;
        logic [COEF_W-1:0] p5;
        logic [COEF_W-1:0] p6;
        logic [COEF_W-1:0] p7;
        logic [COEF_W-1:0] p8;
        logic [COEF_W-1:0] p9;
    } pscc_coef_t;

    // One slot of the divider chain: remainder, dividend bits shifting out at
    // the top while quotient bits shift in at the bottom.
    typedef struct packed {
        logic              vld;
        logic              neg;
        logic              zero;
        logic [DSR_W-1:0]  dsr;
        logic [DSR_W-1:0]  rem;
        logic [DATA_W-1:0] work;
    } pscc_div_t;

    typedef struct packed {
        logic               vld;
        logic               ok;
        logic [PRESS_W-1:0] pressure;
    } pscc_res_t;

endpackage

/* hw/rtl/pscc_div_cell.sv */
`timescale 1ns / 1ps

module pscc_div_cell
    import pscc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  pscc_div_t din,
    output pscc_div_t dout
);

    logic              vld_reg;
    logic              neg_reg;
    logic              zero_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [DSR_W-1:0]  rem_reg;
    logic [DATA_W-1:0] work_reg;

    logic [DSR_W:0]    shifted;
    logic [DSR_W:0]    diff;
    logic              take;
    logic [DSR_W-1:0]  rem_next;
    logic [DATA_W-1:0] work_next;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    always_comb
    begin
        shifted   = {din.rem, din.work[DATA_W-1]};
        diff      = shifted - {1'b0, din.dsr};
        take      = (shifted >= {1'b0, din.dsr});
        rem_next  = take ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
        work_next = {din.work[DATA_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= din.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg  <= din.neg;
            zero_reg <= din.zero;
            dsr_reg  <= din.dsr;
            rem_reg  <= rem_next;
            work_reg <= work_next;
        end
    end

    assign dout = '{vld: vld_reg, neg: neg_reg, zero: zero_reg, dsr: dsr_reg,
                    rem: rem_reg, work: work_reg};

endmodule

/* hw/rtl/pscc_front.sv */
`timescale 1ns / 1ps

module pscc_front
    import pscc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               frame_valid,
    input  logic [FRAME_W-1:0] frame,
    input  pscc_coef_t         coef,
    output pscc_div_t          dout
);

    localparam int NSTAGE = 10;

    logic [NSTAGE-1:0] vld_reg;

    // Stage 1: offsets of the temperature word, first products
    logic [ADC_W-1:0]  adc_t;
    logic signed [17:0] d1;
    logic signed [16:0] d2;
    logic signed [33:0] m1_full;
    logic signed [33:0] m2_full;
    logic [31:0] s1_m1_reg, s1_m1_next;
    logic [31:0] s1_m2_reg, s1_m2_next;
    logic [ADC_W-1:0] s1_adcp_reg, s1_adcp_next;

    // Stage 2
    logic signed [31:0] m1_s;
    logic signed [31:0] m1_sh;
    logic signed [19:0] sq;
    logic signed [35:0] m3_full;
    logic [20:0] s2_v1_reg, s2_v1_next;
    logic [31:0] s2_m3_reg, s2_m3_next;
    logic [ADC_W-1:0] s2_adcp_reg;

    // Stage 3
    logic signed [20:0] v1_s;
    logic signed [17:0] v2_s;
    logic signed [23:0] v1_x;
    logic signed [23:0] v2_x;
    logic signed [23:0] s3_a_reg, s3_a_next;
    logic [ADC_W-1:0] s3_adcp_reg;

    // Stage 4
    logic signed [47:0] s4_aa_reg, s4_aa_next;
    logic signed [39:0] s4_ap5_reg, s4_ap5_next;
    logic signed [39:0] s4_ap2_reg, s4_ap2_next;
    logic [ADC_W-1:0] s4_adcp_reg;

    // Stage 5
    logic signed [63:0] s5_b6_reg, s5_b6_next;
    logic signed [63:0] s5_b3_reg, s5_b3_next;
    logic signed [39:0] s5_ap5_reg;
    logic signed [39:0] s5_ap2_reg;
    logic [ADC_W-1:0] s5_adcp_reg;

    // Stage 6
    logic signed [63:0] ap5_x;
    logic signed [63:0] ap2_x;
    logic signed [63:0] p4_x;
    logic signed [63:0] b3_sh;
    logic signed [63:0] s6_b_reg, s6_b_next;
    logic signed [63:0] s6_x_reg, s6_x_next;
    logic [ADC_W-1:0] s6_adcp_reg;

    // Stage 7
    logic [20:0] p0;
    logic [47:0] s7_plo_reg, s7_plo_next;
    logic [31:0] s7_phi_reg, s7_phi_next;
    logic [63:0] s7_n0_reg, s7_n0_next;

    // Stage 8
    logic [63:0] den_prod;
    logic [30:0] s8_den_reg, s8_den_next;
    logic [43:0] s8_nlo_reg, s8_nlo_next;
    logic [31:0] s8_nhi_reg, s8_nhi_next;

    // Stage 9
    logic [63:0] s9_n_reg, s9_n_next;
    logic [30:0] s9_den_reg;

    // Stage 10: magnitudes and signs for the divider
    logic [DSR_W-1:0]  den_x;
    logic [DSR_W-1:0]  s10_dsr_reg, s10_dsr_next;
    logic [DATA_W-1:0] s10_mag_reg, s10_mag_next;
    logic              s10_neg_reg, s10_neg_next;
    logic              s10_zero_reg, s10_zero_next;

    always_comb
    begin
        adc_t      = frame[23:4];
        d1         = $signed({1'b0, adc_t[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
        d2         = $signed({1'b0, adc_t[19:4]}) - $signed({1'b0, coef.t1});
        m1_full    = d1 * $signed(coef.t2);
        m2_full    = d2 * d2;
        s1_m1_next = m1_full[31:0];
        s1_m2_next = m2_full[31:0];
        s1_adcp_next = frame[47:28];
    end

    always_comb
    begin
        m1_s       = s1_m1_reg;
        m1_sh      = m1_s >>> 11;
        s2_v1_next = m1_sh[20:0];
        sq         = s1_m2_reg[31:12];
        m3_full    = sq * $signed(coef.t3);
        s2_m3_next = m3_full[31:0];
    end

    always_comb
    begin
        v1_s      = s2_v1_reg;
        v2_s      = s2_m3_reg[31:14];
        v1_x      = v1_s;
        v2_x      = v2_s;
        s3_a_next = v1_x + v2_x - T_OFFSET;
    end

    always_comb
    begin
        s4_aa_next  = s3_a_reg * s3_a_reg;
        s4_ap5_next = s3_a_reg * $signed(coef.p5);
        s4_ap2_next = s3_a_reg * $signed(coef.p2);
    end

    always_comb
    begin
        s5_b6_next = s4_aa_reg * $signed(coef.p6);
        s5_b3_next = s4_aa_reg * $signed(coef.p3);
    end

    always_comb
    begin
        ap5_x     = s5_ap5_reg;
        ap2_x     = s5_ap2_reg;
        p4_x      = $signed(coef.p4);
        b3_sh     = s5_b3_reg >>> 8;
        s6_b_next = s5_b6_reg + (ap5_x <<< 17) + (p4_x <<< 35);
        s6_x_next = 64'sh0000_8000_0000_0000 + b3_sh + (ap2_x <<< 12);
    end

    always_comb
    begin
        s7_plo_next = s6_x_reg[31:0] * coef.p1;
        s7_phi_next = s6_x_reg[63:32] * {16'b0, coef.p1};
        p0          = P_FULL_SCALE - {1'b0, s6_adcp_reg};
        s7_n0_next  = {12'b0, p0, 31'b0} - s6_b_reg;
    end

    always_comb
    begin
        den_prod    = {16'b0, s7_plo_reg} + {s7_phi_reg, 32'b0};
        s8_den_next = den_prod[63:33];
        s8_nlo_next = s7_n0_reg[31:0] * P_SCALE;
        s8_nhi_next = s7_n0_reg[63:32] * {20'b0, P_SCALE};
    end

    assign s9_n_next = {20'b0, s8_nlo_reg} + {s8_nhi_reg, 32'b0};

    always_comb
    begin
        den_x         = {s9_den_reg[30], s9_den_reg};
        s10_dsr_next  = s9_den_reg[30] ? (~den_x + 1'b1) : den_x;
        s10_mag_next  = s9_n_reg[63] ? (~s9_n_reg + 1'b1) : s9_n_reg;
        s10_neg_next  = s9_n_reg[63] ^ s9_den_reg[30];
        s10_zero_next = (s9_den_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTAGE-2:0], frame_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_m1_reg    <= s1_m1_next;
            s1_m2_reg    <= s1_m2_next;
            s1_adcp_reg  <= s1_adcp_next;
            s2_v1_reg    <= s2_v1_next;
            s2_m3_reg    <= s2_m3_next;
            s2_adcp_reg  <= s1_adcp_reg;
            s3_a_reg     <= s3_a_next;
            s3_adcp_reg  <= s2_adcp_reg;
            s4_aa_reg    <= s4_aa_next;
            s4_ap5_reg   <= s4_ap5_next;
            s4_ap2_reg   <= s4_ap2_next;
            s4_adcp_reg  <= s3_adcp_reg;
            s5_b6_reg    <= s5_b6_next;
            s5_b3_reg    <= s5_b3_next;
            s5_ap5_reg   <= s4_ap5_reg;
            s5_ap2_reg   <= s4_ap2_reg;
            s5_adcp_reg  <= s4_adcp_reg;
            s6_b_reg     <= s6_b_next;
            s6_x_reg     <= s6_x_next;
            s6_adcp_reg  <= s5_adcp_reg;
            s7_plo_reg   <= s7_plo_next;
            s7_phi_reg   <= s7_phi_next;
            s7_n0_reg    <= s7_n0_next;
            s8_den_reg   <= s8_den_next;
            s8_nlo_reg   <= s8_nlo_next;
            s8_nhi_reg   <= s8_nhi_next;
            s9_n_reg     <= s9_n_next;
            s9_den_reg   <= s8_den_reg;
            s10_dsr_reg  <= s10_dsr_next;
            s10_mag_reg  <= s10_mag_next;
            s10_neg_reg  <= s10_neg_next;
            s10_zero_reg <= s10_zero_next;
        end
    end

    assign dout = '{vld: vld_reg[NSTAGE-1], neg: s10_neg_reg, zero: s10_zero_reg,
                    dsr: s10_dsr_reg, rem: '0, work: s10_mag_reg};

endmodule

/* hw/rtl/pscc_back.sv */
`timescale 1ns / 1ps

module pscc_back
    import pscc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  pscc_div_t  din,
    input  pscc_coef_t coef,
    output pscc_res_t  res
);

    localparam int NSTAGE = 7;

    logic [NSTAGE-1:0] vld_reg;

    // Stage 1: signed quotient
    logic [63:0] b1_q_reg, b1_q_next;
    logic        b1_zero_reg;

    // Stage 2: partial products of p9 * ps and p8 * q
    logic signed [63:0] ps_s;
    logic signed [48:0] b2_ylo_reg, b2_ylo_next;
    logic [31:0] b2_yhi_reg, b2_yhi_next;
    logic signed [48:0] b2_elo_reg, b2_elo_next;
    logic [31:0] b2_ehi_reg, b2_ehi_next;
    logic [63:0] b2_ps_reg;
    logic [63:0] b2_q_reg;
    logic        b2_zero_reg;

    // Stage 3
    logic [63:0] esum;
    logic signed [63:0] e_sh;
    logic [63:0] b3_y_reg, b3_y_next;
    logic [63:0] b3_e_reg, b3_e_next;
    logic [63:0] b3_ps_reg;
    logic [63:0] b3_q_reg;
    logic        b3_zero_reg;

    // Stage 4: partial products of y * ps
    logic [63:0] b4_zll_reg, b4_zll_next;
    logic [31:0] b4_zlh_reg, b4_zlh_next;
    logic [31:0] b4_zhl_reg, b4_zhl_next;
    logic [63:0] b4_e_reg;
    logic [63:0] b4_q_reg;
    logic        b4_zero_reg;

    // Stage 5
    logic [31:0] zmid;
    logic [63:0] zsum;
    logic signed [63:0] c_sh;
    logic [63:0] b5_c_reg, b5_c_next;
    logic [63:0] b5_e_reg;
    logic [63:0] b5_q_reg;
    logic        b5_zero_reg;

    // Stage 6
    logic [63:0] tsum;
    logic signed [63:0] t_sh;
    logic [63:0] b6_r_reg, b6_r_next;
    logic        b6_zero_reg;

    // Stage 7: result register
    logic               ok_next;
    logic [PRESS_W-1:0] pressure_next;
    logic               ok_reg;
    logic [PRESS_W-1:0] pressure_reg;

    assign b1_q_next = din.neg ? (~din.work + 1'b1) : din.work;

    always_comb
    begin
        ps_s        = $signed(b1_q_reg) >>> 13;
        b2_ylo_next = $signed({1'b0, ps_s[31:0]}) * $signed(coef.p9);
        b2_yhi_next = ps_s[63:32] * {{16{coef.p9[15]}}, coef.p9};
        b2_elo_next = $signed({1'b0, b1_q_reg[31:0]}) * $signed(coef.p8);
        b2_ehi_next = b1_q_reg[63:32] * {{16{coef.p8[15]}}, coef.p8};
    end

    always_comb
    begin
        b3_y_next = {{15{b2_ylo_reg[48]}}, b2_ylo_reg} + {b2_yhi_reg, 32'b0};
        esum      = {{15{b2_elo_reg[48]}}, b2_elo_reg} + {b2_ehi_reg, 32'b0};
        e_sh      = $signed(esum) >>> 19;
        b3_e_next = e_sh;
    end

    always_comb
    begin
        b4_zll_next = b3_y_reg[31:0] * b3_ps_reg[31:0];
        b4_zlh_next = b3_y_reg[31:0] * b3_ps_reg[63:32];
        b4_zhl_next = b3_y_reg[63:32] * b3_ps_reg[31:0];
    end

    always_comb
    begin
        zmid      = b4_zlh_reg + b4_zhl_reg;
        zsum      = b4_zll_reg + {zmid, 32'b0};
        c_sh      = $signed(zsum) >>> 25;
        b5_c_next = c_sh;
    end

    always_comb
    begin
        tsum      = b5_q_reg + b5_c_reg + b5_e_reg;
        t_sh      = $signed(tsum) >>> 8;
        b6_r_next = t_sh + {{44{coef.p7[15]}}, coef.p7, 4'b0};
    end

    // Drop results with a zero divisor or a non-positive value, saturate above the Q24.8 range
    always_comb
    begin
        ok_next = !b6_zero_reg && !b6_r_reg[63] && (b6_r_reg != '0);
        if (!ok_next)
        begin
            pressure_next = '0;
        end
        else if (b6_r_reg[63:32] != '0)
        begin
            pressure_next = '1;
        end
        else
        begin
            pressure_next = b6_r_reg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTAGE-2:0], din.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_q_reg     <= b1_q_next;
            b1_zero_reg  <= din.zero;
            b2_ylo_reg   <= b2_ylo_next;
            b2_yhi_reg   <= b2_yhi_next;
            b2_elo_reg   <= b2_elo_next;
            b2_ehi_reg   <= b2_ehi_next;
            b2_ps_reg    <= ps_s;
            b2_q_reg     <= b1_q_reg;
            b2_zero_reg  <= b1_zero_reg;
            b3_y_reg     <= b3_y_next;
            b3_e_reg     <= b3_e_next;
            b3_ps_reg    <= b2_ps_reg;
            b3_q_reg     <= b2_q_reg;
            b3_zero_reg  <= b2_zero_reg;
            b4_zll_reg   <= b4_zll_next;
            b4_zlh_reg   <= b4_zlh_next;
            b4_zhl_reg   <= b4_zhl_next;
            b4_e_reg     <= b3_e_reg;
            b4_q_reg     <= b3_q_reg;
            b4_zero_reg  <= b3_zero_reg;
            b5_c_reg     <= b5_c_next;
            b5_e_reg     <= b4_e_reg;
            b5_q_reg     <= b4_q_reg;
            b5_zero_reg  <= b4_zero_reg;
            b6_r_reg     <= b6_r_next;
            b6_zero_reg  <= b5_zero_reg;
            ok_reg       <= ok_next;
            pressure_reg <= pressure_next;
        end
    end

    assign res = '{vld: vld_reg[NSTAGE-1], ok: ok_reg, pressure: pressure_reg};

endmodule

/* hw/rtl/pressure_sensor_compensation_core.sv */
`timescale 1ns / 1ps

// Barometric pressure compensation, 64-bit integer form. Each transfer on the
// sample channel carries one raw six-byte frame (pressure ADC in bits 47:28,
// temperature ADC in bits 23:4); each transfer on the result channel returns
// the compensated pressure in pascal as unsigned Q24.8 together with valid_res,
// which is low (and pressure_fixed zero) when the divisor is zero or the
// pressure is not positive. Positive pressures beyond the Q24.8 range saturate
// to all ones. The block is fully pipelined and takes one frame every cycle;
// a frame passes through 10 stages that form the fine temperature, the divisor
// and the numerator, a chain of 64 division cells that resolve one quotient
// bit each, and 7 stages that apply the final terms. The whole pipeline
// holds while a result waits under result_stall, so sample_stall follows
// result_stall whenever a result is on offer. The twelve
// calibration words live in four 64-bit registers on the APB port at byte
// addresses 0x00 (T1..T3), 0x08 (P1..P4), 0x10 (P5..P8) and 0x18 (P9); write
// them only while no frame is in flight.

module pressure_sensor_compensation_core
    import pscc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,

    input  logic                sample_valid,
    output logic                sample_stall,
    input  logic [FRAME_W-1:0]  sample_frame,

    output logic                result_valid,
    input  logic                result_stall,
    output logic [PRESS_W-1:0]  pressure_fixed,
    output logic                valid_res
);

    logic [47:0]        temp_reg;
    logic [DATA_W-1:0]  plow_reg;
    logic [DATA_W-1:0]  phigh_reg;
    logic [COEF_W-1:0]  pnine_reg;

    logic       cfg_wr;
    logic [1:0] cfg_idx;
    logic       en;

    pscc_coef_t coef;
    pscc_res_t  res;
    pscc_div_t  chain [0:DIV_STEPS];

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg  <= '0;
            plow_reg  <= '0;
            phigh_reg <= '0;
            pnine_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_TEMP:       temp_reg  <= pwdata[47:0];
                REG_PRESS_LOW:  plow_reg  <= pwdata;
                REG_PRESS_HIGH: phigh_reg <= pwdata;
                REG_PRESS_NINE: pnine_reg <= pwdata[COEF_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_TEMP:       prdata = {16'b0, temp_reg};
            REG_PRESS_LOW:  prdata = plow_reg;
            REG_PRESS_HIGH: prdata = phigh_reg;
            REG_PRESS_NINE: prdata = {48'b0, pnine_reg};
            default:        prdata = '0;
        endcase
    end

    assign coef = '{t1: temp_reg[47:32],  t2: temp_reg[31:16],  t3: temp_reg[15:0],
                    p1: plow_reg[63:48],  p2: plow_reg[47:32],  p3: plow_reg[31:16],
                    p4: plow_reg[15:0],   p5: phigh_reg[63:48], p6: phigh_reg[47:32],
                    p7: phigh_reg[31:16], p8: phigh_reg[15:0],  p9: pnine_reg};

    // Advance every stage unless a finished result is held under stall
    assign en           = !res.vld || !result_stall;
    assign sample_stall = !en;

    pscc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .frame_valid (sample_valid),
        .frame       (sample_frame),
        .coef        (coef),
        .dout        (chain[0])
    );

    // Division chain: one quotient bit per cell
    for (genvar gi = 0; gi < DIV_STEPS; gi++)
    begin : g_div
        pscc_div_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (chain[gi]),
            .dout  (chain[gi+1])
        );
    end

    pscc_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (chain[DIV_STEPS]),
        .coef  (coef),
        .res   (res)
    );

    assign result_valid   = res.vld;
    assign pressure_fixed = res.pressure;
    assign valid_res      = res.ok;

`ifndef SYNTHESIS
    // A rejected result carries no pressure
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !valid_res |-> pressure_fixed == '0)
        else $error("rejected result carries a nonzero pressure");

    // An accepted result always carries a nonzero pressure
    a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && valid_res |-> pressure_fixed != '0)
        else $error("accepted result carries zero pressure");
`endif

endmodule
